// File: design/thsd_pkg.sv
package thsd_pkg;

  // Display digit codes
  localparam logic [3:0] CODE_BLANK = 4'd10;
  localparam logic [3:0] CODE_MINUS = 4'd11;
  localparam logic [3:0] CODE_E     = 4'd12;
  localparam logic [3:0] CODE_R     = 4'd13;

  // Sample range constants
  localparam logic [15:0] NEG_MASK  = 16'hF800;
  localparam logic [15:0] INT_MASK  = 16'h07F0;
  localparam logic [15:0] NEG_LIMIT = 16'hFC90;
  localparam logic [15:0] POS_LIMIT = 16'h07D0;

  // Register reset values
  localparam logic [15:0] SETPOINT_RST   = 16'h0140;
  localparam logic [10:0] ZONE_RST       = 11'h008;
  localparam logic [15:0] ERROR_CODE_RST = 16'hFFFF;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT   = 3'd0,
    REG_ZONE       = 3'd1,
    REG_SHOW_EN    = 3'd2,
    REG_CTRL_EN    = 3'd3,
    REG_ERROR_CODE = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] setpoint;
    logic [10:0] zone;
    logic        show_en;
    logic        ctrl_en;
    logic [15:0] error_code;
  } cfg_t;

  typedef struct packed {
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] units;
    logic [3:0] tenths;
  } digits_t;

  // Rounded tenths digit from a 1/16 fraction: round(floor(f*6.25)/10)
  function automatic logic [3:0] tenth_of(input logic [3:0] f);
    logic [3:0] d;
    case (f)
      4'd0:    d = 4'd0;
      4'd1:    d = 4'd1;
      4'd2:    d = 4'd1;
      4'd3:    d = 4'd2;
      4'd4:    d = 4'd3;
      4'd5:    d = 4'd3;
      4'd6:    d = 4'd4;
      4'd7:    d = 4'd4;
      4'd8:    d = 4'd5;
      4'd9:    d = 4'd6;
      4'd10:   d = 4'd6;
      4'd11:   d = 4'd7;
      4'd12:   d = 4'd8;
      4'd13:   d = 4'd8;
      4'd14:   d = 4'd9;
      default: d = 4'd9;
    endcase
    return d;
  endfunction

endpackage

// File: design/thsd_digits.sv
module thsd_digits (
  input  thsd_pkg::cfg_t    cfg,
  input  logic [15:0]       temp,
  output thsd_pkg::digits_t digits
);
  import thsd_pkg::*;

  logic        neg;
  logic [15:0] mag;
  logic [6:0]  ip;
  logic        ge100;
  logic        ge10;
  logic [6:0]  ip_lo;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [6:0]  units7;

  assign neg   = (temp & NEG_MASK) == NEG_MASK;
  assign mag   = neg ? (~temp + 16'd1) : temp;
  assign ip    = 7'((mag & INT_MASK) >> 4);
  assign ge100 = ip >= 7'd100;
  assign ge10  = ip >= 7'd10;
  assign ip_lo = ge100 ? ip - 7'd100 : ip;

  // divide by 10 via reciprocal, exact for 0..99
  assign prod     = 15'(ip_lo) * 15'd205;
  assign tens     = prod[14:11];
  assign tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
  assign units7   = ip_lo - tens_x10;

  always_comb begin
    digits = '0;
    if (cfg.show_en) begin
      if (temp == cfg.error_code) begin
        digits.hundreds = CODE_BLANK;
        digits.tens     = CODE_E;
        digits.units    = CODE_R;
        digits.tenths   = CODE_R;
      end else begin
        if (ge100)           digits.hundreds = 4'd1;
        else if (neg && ge10) digits.hundreds = CODE_MINUS;
        else                 digits.hundreds = CODE_BLANK;

        if (ge10)     digits.tens = tens;
        else if (neg) digits.tens = CODE_MINUS;
        else          digits.tens = CODE_BLANK;

        digits.units  = units7[3:0];
        digits.tenths = tenth_of(mag[3:0]);
      end
    end
  end

endmodule

// File: design/thsd_ctrl.sv
module thsd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  thsd_pkg::cfg_t cfg,
  input  logic [15:0]    temp,
  input  logic           adv,
  output logic           heater_on
);
  import thsd_pkg::*;

  logic        heater_r;
  logic        heater_nxt;
  logic [9:0]  half;
  logic [15:0] ton;
  logic [15:0] toff;
  logic        ton_pos;
  logic        toff_neg;
  logic        decide;

  assign half     = cfg.zone[10:1];
  assign ton      = cfg.setpoint - 16'(half);
  assign toff     = cfg.setpoint + 16'(half);
  assign ton_pos  = ton <= POS_LIMIT;
  assign toff_neg = toff >= NEG_LIMIT;

  // bang-bang with wrap-aware range checks on the thresholds
  always_comb begin
    decide = heater_r;
    if (temp >= NEG_LIMIT) begin
      if (ton_pos || temp <= ton)          decide = 1'b1;
      else if (toff_neg && temp >= toff)   decide = 1'b0;
    end else begin
      if (ton_pos && temp <= ton)          decide = 1'b1;
      else if (toff_neg || temp >= toff)   decide = 1'b0;
    end
  end

  assign heater_nxt = cfg.ctrl_en ? decide : heater_r;
  assign heater_on  = heater_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heater_r <= 1'b0;
    end else if (adv) begin
      heater_r <= heater_nxt;
    end
  end

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && cfg.ctrl_en) |=> $stable(heater_r))
    else $error("heater changed without an enabled control step");

  a_on_below: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && cfg.ctrl_en && temp < NEG_LIMIT && ton_pos && temp <= ton) |=> heater_r)
    else $error("heater not on at or below on threshold");

  a_off_above: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && cfg.ctrl_en && temp < NEG_LIMIT && !ton_pos && temp >= toff) |=> !heater_r)
    else $error("heater not off at or above off threshold");

endmodule

// File: design/thermostat_sample_display_and_relay.sv
// Thermostat sample path: display digits and hysteresis heater relay.
//
// in_*   : one 16-bit raw sensor word per transfer (two's complement, 1/16 deg).
// out_*  : one result word per input word, tdata fields from bit 0 up:
//          hundreds[3:0], tens[7:4], units[11:8], tenths[15:12],
//          display_update[16], heater_on[17], zero pad [23:18].
// cfg_*  : write port, index 0 setpoint, 1 zone, 2 show enable,
//          3 control enable, 4 error code. Write only while idle.
//
// Pipeline: input register -> digit decode and hysteresis compare -> output
// register. A word moves from the input register to the output register once
// that is empty or being taken; throughput is one word per cycle while out_tready
// is high, since stage 1 empties in the same cycle the output register is taken.
// A stalled receiver holds the output register; the input register still
// takes one more word, after which in_tready drops until the result drains.
// Reset (rst_n low, synchronous) empties both stages, turns the heater off
// and loads the register reset values.
module thermostat_sample_display_and_relay (
  input  logic                               clk,
  input  logic                               rst_n,
  // slave side: tdata = temp_raw[15:0]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [thsd_pkg::IN_DATA_W-1:0]     in_tdata,
  // master side: tdata = hundreds, tens, units, tenths, display_update, heater_on
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [thsd_pkg::OUT_DATA_W-1:0]    out_tdata,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [thsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [thsd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import thsd_pkg::*;

  cfg_t                  cfg_r;
  logic                  s1_valid_r;
  logic [15:0]           s1_temp_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;
  logic                  s1_move;
  logic                  heater_on;
  digits_t               digits;

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint   <= SETPOINT_RST;
      cfg_r.zone       <= ZONE_RST;
      cfg_r.show_en    <= 1'b1;
      cfg_r.ctrl_en    <= 1'b0;
      cfg_r.error_code <= ERROR_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SETPOINT:   cfg_r.setpoint   <= cfg_wdata;
        REG_ZONE:       cfg_r.zone       <= cfg_wdata[10:0];
        REG_SHOW_EN:    cfg_r.show_en    <= cfg_wdata[0];
        REG_CTRL_EN:    cfg_r.ctrl_en    <= cfg_wdata[0];
        REG_ERROR_CODE: cfg_r.error_code <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- handshake: stage 1 drains when output is empty or being taken ----
  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_temp_r <= in_tdata;
    end
  end

  // ---- per-word logic ----
  thsd_digits u_digits (
    .cfg    (cfg_r),
    .temp   (s1_temp_r),
    .digits (digits)
  );

  // heater state advances only when a word leaves stage 1
  thsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .temp      (s1_temp_r),
    .adv       (s1_move),
    .heater_on (heater_on)
  );

  assign out_data_nxt = {6'b000000, heater_on, cfg_r.show_en,
                         digits.tenths, digits.units, digits.tens, digits.hundreds};

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled with room in the pipeline");

  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("word left stage 1 but output register empty");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !s1_move)
    else $error("pending result overwritten");

  a_disp_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r[16]) |-> (out_data_r[15:0] == 16'h0000))
    else $error("digits nonzero with display update low");

endmodule

// File: verif/thsd_readout_checker.sv
module thsd_readout_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [thsd_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [thsd_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [thsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [thsd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                     failures,
  output int unsigned                     pending,
  output int unsigned                     checked,
  output int unsigned                     heated
);
  timeunit 1ns;
  timeprecision 1ps;
  import thsd_pkg::*;

  typedef struct packed {
    digits_t dig;
    logic    upd;
    logic    heat;
  } readout_t;

  // shadow registers and relay state
  logic [15:0] setpt;
  logic [10:0] zone;
  logic        show_on;
  logic        ctrl_on;
  logic [15:0] err_word;
  logic        relay_on;

  readout_t    readouts_due[$];
  int unsigned n_fail = 0;
  int unsigned n_checked = 0;
  int unsigned n_heated = 0;

  function automatic digits_t digits_of(input logic [15:0] t);
    digits_t     d;
    logic        neg;
    logic [15:0] mag;
    int unsigned ip, q, tenth;
    if (t == err_word) begin
      d.hundreds = CODE_BLANK;
      d.tens     = CODE_E;
      d.units    = CODE_R;
      d.tenths   = CODE_R;
      return d;
    end
    // negative only when the top five bits are all set
    neg   = &t[15:11];
    mag   = neg ? (~t + 16'd1) : t;
    ip    = mag[10:4];
    q     = mag[3:0] * 625 / 100;
    tenth = q / 10 + ((q % 10 >= 5) ? 1 : 0);
    if (ip >= 100)
      d.hundreds = 4'd1;
    else if (neg && ip >= 10)
      d.hundreds = CODE_MINUS;
    else
      d.hundreds = CODE_BLANK;
    if (ip >= 10)
      d.tens = 4'((ip % 100) / 10);
    else if (neg)
      d.tens = CODE_MINUS;
    else
      d.tens = CODE_BLANK;
    d.units  = 4'(ip % 10);
    d.tenths = 4'(tenth);
    return d;
  endfunction

  // bang-bang step; thresholds wrap at 16 bits
  task automatic step_relay(input logic [15:0] t);
    logic [15:0] half, ton, toff;
    half = {6'd0, zone[10:1]};
    ton  = setpt - half;
    toff = setpt + half;
    if (t >= NEG_LIMIT) begin
      if (ton <= POS_LIMIT || t <= ton)
        relay_on = 1'b1;
      else if (toff >= NEG_LIMIT && t >= toff)
        relay_on = 1'b0;
    end else begin
      if (ton <= POS_LIMIT && t <= ton)
        relay_on = 1'b1;
      else if (toff >= NEG_LIMIT || t >= toff)
        relay_on = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    if (n_fail < 50)
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
    n_fail++;
  endtask

  always @(posedge clk) begin : watch
    readout_t want;
    if (!rst_n) begin
      setpt    = SETPOINT_RST;
      zone     = ZONE_RST;
      show_on  = 1'b1;
      ctrl_on  = 1'b0;
      err_word = ERROR_CODE_RST;
      relay_on = 1'b0;
      readouts_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SETPOINT:   setpt    = cfg_wdata;
          REG_ZONE:       zone     = cfg_wdata[10:0];
          REG_SHOW_EN:    show_on  = cfg_wdata[0];
          REG_CTRL_EN:    ctrl_on  = cfg_wdata[0];
          REG_ERROR_CODE: err_word = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        want.dig = show_on ? digits_of(in_tdata) : '0;
        want.upd = show_on;
        if (ctrl_on)
          step_relay(in_tdata);
        want.heat = relay_on;
        readouts_due.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        n_checked++;
        if (readouts_due.size() == 0) begin
          report_mismatch("unexpected word", '0, out_tdata[15:0]);
        end else begin
          want = readouts_due.pop_front();
          if (out_tdata[3:0] !== want.dig.hundreds)
            report_mismatch("hundreds", want.dig.hundreds, out_tdata[3:0]);
          if (out_tdata[7:4] !== want.dig.tens)
            report_mismatch("tens", want.dig.tens, out_tdata[7:4]);
          if (out_tdata[11:8] !== want.dig.units)
            report_mismatch("units", want.dig.units, out_tdata[11:8]);
          if (out_tdata[15:12] !== want.dig.tenths)
            report_mismatch("tenths", want.dig.tenths, out_tdata[15:12]);
          if (out_tdata[16] !== want.upd)
            report_mismatch("display_update", want.upd, out_tdata[16]);
          if (out_tdata[17] !== want.heat)
            report_mismatch("heater_on", want.heat, out_tdata[17]);
          if (want.heat)
            n_heated++;
        end
      end
    end
    failures <= n_fail;
    pending  <= readouts_due.size();
    checked  <= n_checked;
    heated   <= n_heated;
  end

endmodule

// File: verif/tb_thermostat_sample_display_and_relay.sv
module tb_thermostat_sample_display_and_relay;
  timeunit 1ns;
  timeprecision 1ps;
  import thsd_pkg::*;

  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 68;
  // receiver freezes once for a long stretch after this many words
  localparam int HOLD_AT     = 270;
  localparam int HOLD_CYCLES = 60;

  // display path corners under reset settings (error word is 16'hFFFF)
  localparam int N_DIGIT_CASES = 17;
  localparam logic [15:0] DIGIT_CASES [0:N_DIGIT_CASES-1] = '{
    16'h0000, 16'h0001, 16'h0008, 16'h000F, 16'h00A0, 16'h0640, 16'h07D0,
    16'h07FF, 16'h0800, 16'h7FFF, 16'h8000, 16'hF800, 16'hF801, 16'hFC90,
    16'hFF60, 16'hFFF8, 16'hFFFF
  };

  // relay walk with setpoint 320, zone 8: on at 316, off at 324
  localparam int N_RELAY_CASES = 8;
  localparam logic [15:0] RELAY_CASES [0:N_RELAY_CASES-1] = '{
    16'd318, 16'd316, 16'd320, 16'd324, 16'd322, 16'hFFF0, 16'h07D1, 16'h0000
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // temp_raw[15:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // hundreds[3:0], tens[7:4], units[11:8], tenths[15:12],
  // display_update[16], heater_on[17], pad[23:18]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SETPOINT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int unsigned failures, pending, checked, heated;
  int unsigned sent = 0;
  int unsigned rx_words = 0;
  int unsigned settings = 1;

  // steady modes give stretches with no idling on either side
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;

  // settings in force, used to aim samples at the thresholds
  logic [15:0] cur_sp   = SETPOINT_RST;
  logic [10:0] cur_zone = ZONE_RST;
  logic [15:0] cur_err  = ERROR_CODE_RST;

  thermostat_sample_display_and_relay dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  thsd_readout_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .failures   (failures),
    .pending    (pending),
    .checked    (checked),
    .heated     (heated)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #(2_000_000);
    $display("tb_thermostat_sample_display_and_relay failed");
    $finish;
  end

  // one register write per cycle; cfg_we stays high across a burst
  task automatic put_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] sp, input logic [10:0] zn,
                                input logic sh, input logic ct,
                                input logic [15:0] ec);
    put_reg(REG_SETPOINT, sp);
    put_reg(REG_ZONE, {5'd0, zn});
    put_reg(REG_SHOW_EN, {15'd0, sh});
    put_reg(REG_CTRL_EN, {15'd0, ct});
    put_reg(REG_ERROR_CODE, ec);
    cfg_we   <= 1'b0;
    cur_sp   = sp;
    cur_zone = zn;
    cur_err  = ec;
    settings++;
  endtask

  // random gap, then hold the word until the block takes it
  task automatic offer_sample(input logic [15:0] t);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0)
      tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // drop valid, let the checker's pending count take in the last accepted
  // word, then wait for every result
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // samples: half near the setpoint and the on/off thresholds, plus the error word,
  // the sensor's real range, the negative band and raw noise
  function automatic logic [15:0] pick_sample();
    logic [15:0] half, nudge;
    half  = {6'd0, cur_zone[10:1]};
    nudge = 16'($urandom_range(0, 8)) - 16'd4;
    case ($urandom_range(0, 9))
      0, 1:    return 16'($urandom);
      2:       return cur_err;
      3, 4:    return cur_sp - half + nudge;
      5, 6:    return cur_sp + half + nudge;
      7:       return 16'($urandom_range(0, 2880)) - 16'd880;
      8:       return {5'b11111, 11'($urandom)};
      default: return cur_sp + nudge;
    endcase
  endfunction

  // receiver: random stall per word, one long freeze to back up the pipe
  initial begin : receiver
    int unsigned stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_words == HOLD_AT) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 31) == 0)
        rx_steady = !rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      rx_words++;
    end
  end

  initial begin : stimulus
    logic [15:0] sp, ec;
    logic [10:0] zn;
    logic        sh, ct;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // digit decode with reset settings: control off, relay stays off
    for (int i = 0; i < N_DIGIT_CASES; i++)
      offer_sample(DIGIT_CASES[i]);

    // hysteresis walk through on, hold and off, both signs
    settle();
    apply_settings(16'd320, 11'd8, 1'b1, 1'b1, ERROR_CODE_RST);
    for (int i = 0; i < N_RELAY_CASES; i++)
      offer_sample(RELAY_CASES[i]);

    // random phases; first ones pin the register extremes
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin
          sp = 16'h0000; zn = 11'd0; sh = 1'b1; ct = 1'b1; ec = 16'h0000;
        end
        1: begin
          sp = 16'hFFFF; zn = 11'd1600; sh = 1'b0; ct = 1'b1; ec = 16'hFFFF;
        end
        2: begin
          sp = NEG_LIMIT; zn = 11'h7FF; sh = 1'b1; ct = 1'b1; ec = 16'($urandom);
        end
        3: begin
          sp = POS_LIMIT; zn = 11'd1; sh = 1'b1; ct = 1'b1; ec = POS_LIMIT;
        end
        4: begin
          // control off: relay must hold whatever phase 3 left
          sp = SETPOINT_RST; zn = 11'd1600; sh = 1'b1; ct = 1'b0; ec = 16'h8000;
        end
        default: begin
          sp = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 2880)) - 16'd880
                                           : 16'($urandom);
          zn = ($urandom_range(0, 3) == 0) ? 11'($urandom)
                                           : 11'($urandom_range(1, 1600));
          sh = ($urandom_range(0, 3) != 0);
          ct = ($urandom_range(0, 3) != 0);
          ec = ($urandom_range(0, 1) == 0) ? ERROR_CODE_RST : 16'($urandom);
        end
      endcase
      apply_settings(sp, zn, sh, ct, ec);
      repeat (PHASE_WORDS) offer_sample(pick_sample());
    end

    // drain, then a few cycles for anything stray to show up
    settle();
    repeat (8) @(posedge clk);

    $display("ran %0d samples across %0d register settings", sent, settings);
    $display("compared %0d result words, %0d with the heater on", checked, heated);
    if (failures == 0 && pending == 0)
      $display("tb_thermostat_sample_display_and_relay passed");
    else
      $display("tb_thermostat_sample_display_and_relay failed");
    $finish;
  end

endmodule

// File: thermostat_sample_display_and_relay.f
design/thsd_pkg.sv
design/thsd_digits.sv
design/thsd_ctrl.sv
design/thermostat_sample_display_and_relay.sv
verif/thsd_readout_checker.sv
verif/tb_thermostat_sample_display_and_relay.sv
